>>> hdl/deq_pkg.sv
// shared constants, command codes and a pointer helper for the double-ended queue
package deq_pkg;

    localparam int CAPACITY    = 1024;
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int COUNT_OUT_W = 11;
    localparam int PTR_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int SUM_W       = PTR_W + 1;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [SUM_W-1:0]  sum_t;
    typedef logic [DATA_W-1:0] word_t;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4
    } cmd_t;

    // reduce a pointer sum that stays below twice the capacity
    function automatic ptr_t wrap_ptr(input sum_t s);
        sum_t diff;
        diff = s - sum_t'(CAPACITY);
        if (s >= sum_t'(CAPACITY))
        begin
            return ptr_t'(diff);
        end
        return ptr_t'(s);
    endfunction

endpackage

>>> hdl/double_ended_queue_top.sv
// double-ended queue of signed words in a ring buffer with cached end entries
//
//  channel   handshake             payload
//  -------   -------------------   -------------------------------------------------
//  in        in_valid / in_stall   cmd, push_value
//  out       out_valid / out_stall popped_value, op_error, entry_count, is_empty,
//                                  front_value, back_value
//
// one command per clock, result in the cycle after the transaction; the single
// result register sets the figure, in_stall only rises while it is full and held
// the ring store has one write and two registered read ports; the reads fetch the
// entries next to each end ahead of time, so a pop finds its new end in a register
// reset clears pointer, count and output valid; store contents stay undefined
module double_ended_queue_top
    import deq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [CMD_W-1:0]              cmd,
    input  logic signed [DATA_W-1:0]      push_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_W-1:0]      popped_value,
    output logic                          op_error,
    output logic [COUNT_OUT_W-1:0]        entry_count,
    output logic                          is_empty,
    output logic signed [DATA_W-1:0]      front_value,
    output logic signed [DATA_W-1:0]      back_value
);

    word_t mem [CAPACITY];

    ptr_t  head_reg, head_next;
    cnt_t  count_reg, count_next;
    word_t front_reg, front_next;
    word_t back_reg, back_next;

    // entries at offset 1 and at offset count-2, read ahead into registers
    word_t rd_front_reg, rd_back_reg;
    ptr_t  rd_front_addr, rd_back_addr;
    logic  byp_front_reg, byp_front_next;
    logic  byp_back_reg, byp_back_next;
    word_t wr_data_reg;

    logic  wr_en;
    ptr_t  wr_addr;

    word_t second_front, second_back;
    logic  accept;
    logic  full, empty, two_or_more;

    word_t popped_next;
    logic  err_next;

    logic  out_valid_reg, out_valid_next;
    word_t popped_reg, front_out_reg, back_out_reg;
    logic  err_reg, empty_reg;
    logic [COUNT_OUT_W-1:0] count_out_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign full        = (count_reg == cnt_t'(CAPACITY));
    assign empty       = (count_reg == '0);
    assign two_or_more = (count_reg >= cnt_t'(2));

    // a write in the cycle of the read lands in the register, not in the read data
    assign second_front = byp_front_reg ? wr_data_reg : rd_front_reg;
    assign second_back  = byp_back_reg  ? wr_data_reg : rd_back_reg;

    always_comb
    begin
        head_next   = head_reg;
        count_next  = count_reg;
        front_next  = front_reg;
        back_next   = back_reg;
        popped_next = '0;
        err_next    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = head_reg;

        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_NONE:
                begin
                end
                CMD_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        head_next  = (head_reg == '0) ? ptr_t'(CAPACITY - 1)
                                                      : head_reg - 1'b1;
                        wr_en      = 1'b1;
                        wr_addr    = head_next;
                        count_next = count_reg + 1'b1;
                        front_next = push_value;
                        if (empty)
                        begin
                            back_next = push_value;
                        end
                    end
                end
                CMD_PUSH_BACK:
                begin
                    if (full)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = wrap_ptr(sum_t'(head_reg) + sum_t'(count_reg));
                        count_next = count_reg + 1'b1;
                        back_next  = push_value;
                        if (empty)
                        begin
                            front_next = push_value;
                        end
                    end
                end
                CMD_POP_FRONT:
                begin
                    if (empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        popped_next = front_reg;
                        head_next   = wrap_ptr(sum_t'(head_reg) + sum_t'(1));
                        count_next  = count_reg - 1'b1;
                        if (two_or_more)
                        begin
                            front_next = second_front;
                        end
                    end
                end
                CMD_POP_BACK:
                begin
                    if (empty)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        popped_next = back_reg;
                        count_next  = count_reg - 1'b1;
                        if (two_or_more)
                        begin
                            back_next = second_back;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // prefetch addresses follow the state after this step
    always_comb
    begin
        rd_front_addr = wrap_ptr(sum_t'(head_next) + sum_t'(1));
        rd_back_addr  = head_next;
        if (count_next >= cnt_t'(2))
        begin
            rd_back_addr = wrap_ptr(sum_t'(head_next) + sum_t'(count_next - cnt_t'(2)));
        end
        byp_front_next = wr_en && (wr_addr == rd_front_addr);
        byp_back_next  = wr_en && (wr_addr == rd_back_addr);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= push_value;
        end
        rd_front_reg <= mem[rd_front_addr];
        rd_back_reg  <= mem[rd_back_addr];
        wr_data_reg  <= push_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            byp_front_reg <= 1'b0;
            byp_back_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            count_reg     <= count_next;
            byp_front_reg <= byp_front_next;
            byp_back_reg  <= byp_back_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg <= front_next;
        back_reg  <= back_next;
        if (accept)
        begin
            popped_reg    <= popped_next;
            err_reg       <= err_next;
            count_out_reg <= COUNT_OUT_W'(count_next);
            empty_reg     <= (count_next == '0);
            front_out_reg <= (count_next == '0) ? '0 : front_next;
            back_out_reg  <= (count_next == '0) ? '0 : back_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign popped_value = popped_reg;
    assign op_error     = err_reg;
    assign entry_count  = count_out_reg;
    assign is_empty     = empty_reg;
    assign front_value  = front_out_reg;
    assign back_value   = back_out_reg;

endmodule

>>> tb/testbench.sv
// self-checking testbench for the double-ended queue with its own deque predictor
module testbench
    import deq_pkg::*;
;

    localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
    localparam word_t WORD_MAX        = 32'h7fff_ffff;
    localparam word_t WORD_MIN        = 32'h8000_0000;
    localparam word_t WORD_ALT_LO     = 32'h5555_5555;
    localparam word_t WORD_ALT_HI     = 32'haaaa_aaaa;
    localparam int    RANDOM_ITEMS    = 800;
    localparam int    RANDOM_SEGMENTS = 8;
    localparam int    HOLD_OFF_CYCLES = 300;
    localparam int    STUCK_LIMIT     = 2000;
    localparam int    DRAIN_CYCLES    = 8;
    localparam int    REPORT_LINES    = 40;

    typedef struct {
        word_t                   popped;
        logic                    err;
        logic [COUNT_OUT_W-1:0]  count;
        logic                    empty;
        word_t                   front;
        word_t                   back;
    } deq_result_t;

    logic                     clk        = 1'b0;
    logic                     rst_n      = 1'b0;
    logic                     in_valid   = 1'b0;
    logic                     in_stall;
    logic [CMD_W-1:0]         cmd        = '0;
    logic signed [DATA_W-1:0] push_value = '0;
    logic                     out_valid;
    logic                     out_stall  = 1'b0;
    logic signed [DATA_W-1:0] popped_value;
    logic                     op_error;
    logic [COUNT_OUT_W-1:0]   entry_count;
    logic                     is_empty;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;

    // predictor state
    word_t       model_ring [CAPACITY];
    int          model_head = 0;
    int          model_held = 0;
    deq_result_t pending_results [$];

    int mismatch_count = 0;
    int stuck_cycles   = 0;
    int send_gap_max   = 0;
    int recv_gap_max   = 0;
    int hold_request   = 0;

    double_ended_queue_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .push_value   (push_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .popped_value (popped_value),
        .op_error     (op_error),
        .entry_count  (entry_count),
        .is_empty     (is_empty),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    always #2 clk = ~clk;

    function automatic int ring_slot(input int offset);
        return (model_head + offset) % CAPACITY;
    endfunction

    function automatic deq_result_t deque_model_step(input logic [CMD_W-1:0] c, input word_t v);
        deq_result_t r;
        r = '{default: '0};
        if (c == CMD_PUSH_FRONT || c == CMD_PUSH_BACK)
        begin
            if (model_held >= CAPACITY)
            begin
                r.err = 1'b1;
            end
            else if (c == CMD_PUSH_FRONT)
            begin
                model_head = (model_head + CAPACITY - 1) % CAPACITY;
                model_ring[model_head] = v;
                model_held++;
            end
            else
            begin
                model_ring[ring_slot(model_held)] = v;
                model_held++;
            end
        end
        else if (c == CMD_POP_FRONT || c == CMD_POP_BACK)
        begin
            if (model_held == 0)
            begin
                r.err = 1'b1;
            end
            else if (c == CMD_POP_FRONT)
            begin
                r.popped = model_ring[ring_slot(0)];
                model_head = ring_slot(1);
                model_held--;
            end
            else
            begin
                r.popped = model_ring[ring_slot(model_held - 1)];
                model_held--;
            end
        end
        if (model_held != 0)
        begin
            r.front = model_ring[ring_slot(0)];
            r.back  = model_ring[ring_slot(model_held - 1)];
        end
        r.count = COUNT_OUT_W'(model_held);
        r.empty = (model_held == 0);
        return r;
    endfunction

    function automatic word_t pick_value();
        case ($urandom_range(0, 7))
            0: return WORD_MAX;
            1: return WORD_MIN;
            2: return '0;
            3: return '1;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return CMD_PUSH_FRONT;
        if (roll < 40)
            return CMD_PUSH_BACK;
        if (roll < 60)
            return CMD_POP_FRONT;
        if (roll < 80)
            return CMD_POP_BACK;
        return CMD_W'($urandom_range(0, 7));
    endfunction

    task automatic report_mismatch(input string what, input word_t got, input word_t want);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES)
            $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // valid stays high between back-to-back transactions
    task automatic send_item(input logic [CMD_W-1:0] c, input word_t v);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        cmd        <= c;
        push_value <= v;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.insert(pending_results.size(), deque_model_step(c, v));
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_gap_max = 7;
        recv_gap_max = 7;
        send_item(CMD_POP_FRONT, pick_value());
        send_item(CMD_POP_BACK, pick_value());
        send_item(CMD_NONE, pick_value());
        for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
            send_item(CMD_W'(c), pick_value());
    endtask

    task automatic test_end_values();
        send_item(CMD_PUSH_BACK, WORD_MAX);
        send_item(CMD_PUSH_FRONT, WORD_MIN);
        send_item(CMD_PUSH_BACK, '0);
        send_item(CMD_PUSH_FRONT, '1);
        send_item(CMD_PUSH_BACK, WORD_ALT_LO);
        send_item(CMD_PUSH_FRONT, WORD_ALT_HI);
        send_item(CMD_NONE, WORD_MAX);
        repeat (3)
        begin
            send_item(CMD_POP_FRONT, WORD_MIN);
            send_item(CMD_POP_BACK, WORD_MAX);
        end
        send_item(CMD_POP_BACK, '0);
    endtask

    task automatic test_full_queue();
        send_gap_max = 0;
        recv_gap_max = 0;
        for (int i = 0; i < CAPACITY; i++)
            send_item($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK, pick_value());
        send_gap_max = 7;
        recv_gap_max = 7;
        send_item(CMD_PUSH_FRONT, pick_value());
        send_item(CMD_PUSH_BACK, pick_value());
        send_item(CMD_NONE, pick_value());
        send_item(CMD_POP_FRONT, pick_value());
        send_item(CMD_PUSH_FRONT, pick_value());
        send_item(CMD_PUSH_BACK, pick_value());
        send_item(CMD_POP_BACK, pick_value());
        send_item(CMD_PUSH_BACK, pick_value());
        send_item(CMD_PUSH_FRONT, pick_value());
        send_gap_max = 1;
        recv_gap_max = 1;
        for (int i = 0; i < CAPACITY; i++)
            send_item($urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK, pick_value());
        send_item(CMD_POP_FRONT, pick_value());
    endtask

    // the receiver holds off long enough for the input side to back up
    task automatic test_backpressure();
        wait_idle();
        send_gap_max = 0;
        recv_gap_max = 0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40)
            send_item(pick_command(), pick_value());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int seg = 0; seg < RANDOM_SEGMENTS; seg++)
        begin
            send_gap_max = (seg % 2 != 0) ? 7 : 0;
            recv_gap_max = (seg % 4 >= 2) ? 7 : 0;
            repeat (RANDOM_ITEMS / RANDOM_SEGMENTS)
                send_item(pick_command(), pick_value());
        end
    endtask

    // receiver: random stall before each transaction, long hold-off on request
    initial
    begin
        int stall_cycles;
        forever
        begin
            stall_cycles = $urandom_range(0, recv_gap_max);
            if (hold_request != 0)
            begin
                stall_cycles = hold_request;
                hold_request = 0;
            end
            if (stall_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (stall_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid && hold_request == 0);
        end
    end

    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                report_mismatch("result with nothing expected", popped_value, '0);
            end
            else
            begin
                want = pending_results[0];
                pending_results.delete(0);
                if (popped_value !== want.popped)
                    report_mismatch("popped_value", popped_value, want.popped);
                if (op_error !== want.err)
                    report_mismatch("op_error", word_t'(op_error), word_t'(want.err));
                if (entry_count !== want.count)
                    report_mismatch("entry_count", word_t'(entry_count), word_t'(want.count));
                if (is_empty !== want.empty)
                    report_mismatch("is_empty", word_t'(is_empty), word_t'(want.empty));
                if (front_value !== want.front)
                    report_mismatch("front_value", front_value, want.front);
                if (back_value !== want.back)
                    report_mismatch("back_value", back_value, want.back);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
        begin
            stuck_cycles <= 0;
        end
        else if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_end_values();
        test_full_queue();
        test_backpressure();
        test_random_traffic();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
